/* rtl/assert_macros.svh */
// Assertion macros shared by the key-value table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define KVT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define KVT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/kvt_pkg.sv */
// Types and constants shared by the key-value table modules.
`default_nettype none

package kvt_pkg;

	localparam int KIND_W   = 2;
	localparam int KEY_W    = 16;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	localparam logic [KIND_W-1:0] KIND_SET = 2'd0;
	localparam logic [KIND_W-1:0] KIND_GET = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DEL = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd2;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} slot_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic scan;
		logic apply;
	} kvt_cmd_t;

	typedef struct packed {
		logic last;
		logic out_busy;
	} kvt_sts_t;

endpackage

`default_nettype wire

/* rtl/kvt_ctrl.sv */
// Controller state machine for the key-value table: clear, scan and update sequencing.
`default_nettype none

module kvt_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire kvt_pkg::kvt_sts_t sts,
	output kvt_pkg::kvt_cmd_t      cmd
);
	import kvt_pkg::*;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_WAIT  = 5'b01000,
		ST_APPLY = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_next;

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.last) begin
					state_next = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.last) begin
					state_next = ST_WAIT;
				end
			end
			ST_WAIT: begin
				// The last slot read is compared during this cycle.
				state_next = ST_APPLY;
			end
			ST_APPLY: begin
				if (!sts.out_busy) begin
					cmd.apply  = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

endmodule

`default_nettype wire

/* rtl/kvt_dpath.sv */
// Datapath of the key-value table: slot memory, scan compare, entry count and result register.
`default_nettype none

module kvt_dpath #(
	parameter int ENTRIES = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire kvt_pkg::kvt_cmd_t              cmd,
	output kvt_pkg::kvt_sts_t                   sts,
	input  wire logic [kvt_pkg::KIND_W-1:0]     kind,
	input  wire logic [kvt_pkg::KEY_W-1:0]      key,
	input  wire logic [kvt_pkg::VAL_W-1:0]      write_value,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [kvt_pkg::STATUS_W-1:0]        status,
	output logic [kvt_pkg::VAL_W-1:0]           read_value,
	output logic [kvt_pkg::COUNT_W-1:0]         entry_count
);
	import kvt_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	slot_t mem [ENTRIES];

	// Request registers.
	logic [KIND_W-1:0] kind_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  value_q;

	// Scan address and the slot read registered from it in the cycle after.
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] idx_s1;
	slot_t            rd_s1;
	logic             vld_s1;

	// Scan results.
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [VAL_W-1:0] hit_val_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;

	logic [CNT_W-1:0] cnt_q;

	// Result register.
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [VAL_W-1:0]    read_value_q;
	logic [COUNT_W-1:0]  entry_count_q;

	logic                key_hit;
	logic                slot_free;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	slot_t               wr_data;
	logic [CNT_W-1:0]    cnt_next;
	logic [STATUS_W-1:0] res_status;
	logic [VAL_W-1:0]    res_value;

	assign key_hit   = vld_s1 && rd_s1.valid && (rd_s1.key == key_q);
	assign slot_free = vld_s1 && !rd_s1.valid;

	// Memory write and result: clears slots while clearing, else decides once the table has been scanned.
	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = hit_idx_q;
		wr_data    = '{valid: 1'b1, key: key_q, value: value_q};
		cnt_next   = cnt_q;
		res_status = STATUS_OK;
		res_value  = '0;
		if (cmd.clear) begin
			wr_en   = 1'b1;
			wr_addr = idx_q;
			wr_data = '0;
		end else if (cmd.apply) begin
			case (kind_q)
				KIND_SET: begin
					if (hit_q) begin
						wr_en = 1'b1;
					end else if (free_q) begin
						wr_en    = 1'b1;
						wr_addr  = free_idx_q;
						cnt_next = cnt_q + CNT_W'(1);
					end else begin
						res_status = STATUS_FULL;
					end
				end
				KIND_GET: begin
					if (hit_q) begin
						res_value = hit_val_q;
					end else begin
						res_status = STATUS_ABSENT;
					end
				end
				KIND_DEL: begin
					if (hit_q) begin
						wr_en    = 1'b1;
						wr_data  = '{valid: 1'b0, key: key_q, value: hit_val_q};
						cnt_next = cnt_q - CNT_W'(1);
					end else begin
						res_status = STATUS_ABSENT;
					end
				end
				default: begin
					res_status = STATUS_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.scan) begin
			rd_s1  <= mem[idx_q];
			idx_s1 <= idx_q;
		end
		if (cmd.load) begin
			kind_q  <= kind;
			key_q   <= key;
			value_q <= write_value;
		end
		if (key_hit && !hit_q) begin
			hit_idx_q <= idx_s1;
			hit_val_q <= rd_s1.value;
		end
		if (slot_free && !free_q) begin
			free_idx_q <= idx_s1;
		end
		if (cmd.apply) begin
			status_q      <= res_status;
			read_value_q  <= res_value;
			entry_count_q <= COUNT_W'(cnt_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			vld_s1      <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan;
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.clear || cmd.scan) begin
				idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + IDX_W'(1);
			end
			// Only the lowest-numbered matching and free slots are kept.
			if (cmd.load) begin
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else begin
				if (key_hit) begin
					hit_q <= 1'b1;
				end
				if (slot_free) begin
					free_q <= 1'b1;
				end
			end
			cnt_q <= cnt_next;
			if (cmd.apply) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.last     = (idx_q == LAST_IDX);
	assign sts.out_busy = out_valid_q && !out_ready;

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign read_value  = read_value_q;
	assign entry_count = entry_count_q;

endmodule

`default_nettype wire

/* rtl/key_value_table_core.sv */
// Top level of the key-value table: controller, datapath and checks.
// A request reads one slot per cycle from the slot memory during its scan; its
// result is then decided in an update step that waits while the previous result
// is still not taken, and the next request is taken only after that update step.
// After reset the slot memory is cleared one slot per cycle with in_ready low; the
// internal entry count resets to zero, and entry_count is first loaded by an update step.
`default_nettype none
`include "assert_macros.svh"

module key_value_table_core #(
	parameter int ENTRIES = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [kvt_pkg::KIND_W-1:0] kind,
	input  wire logic [kvt_pkg::KEY_W-1:0]  key,
	input  wire logic [kvt_pkg::VAL_W-1:0]  write_value,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [kvt_pkg::STATUS_W-1:0]    status,
	output logic [kvt_pkg::VAL_W-1:0]       read_value,
	output logic [kvt_pkg::COUNT_W-1:0]     entry_count
);
	import kvt_pkg::*;

	kvt_cmd_t cmd;
	kvt_sts_t sts;

	kvt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	kvt_dpath #(
		.ENTRIES (ENTRIES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.kind        (kind),
		.key         (key),
		.write_value (write_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.read_value  (read_value),
		.entry_count (entry_count)
	);

	`KVT_ASSERT(a_cmd_onehot0, $onehot0({cmd.clear, cmd.load, cmd.scan, cmd.apply}), "more than one datapath command")
	`KVT_ASSERT(a_transfer_starts_scan, (in_valid && in_ready) |=> cmd.scan, "input transfer not followed by a scan")
	`KVT_ASSERT(a_apply_not_busy, cmd.apply |-> !sts.out_busy, "result overwritten before its transfer")
	`KVT_ASSERT(a_out_from_apply, $rose(out_valid) |-> $past(cmd.apply), "result shown without an update step")

endmodule

`default_nettype wire
